// ===== hw/rtl/dip_pkg.sv =====
// Package for the double integer power core: state codes, operation codes, destination codes and float constants.
package dip_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_UNPACK,
        S_NORM,
        S_MUL,
        S_DIV,
        S_POST,
        S_CHECK,
        S_DENORM,
        S_ROUND,
        S_DONE
    } state_t;

    typedef enum logic {
        OP_MUL,
        OP_RECIP
    } op_t;

    typedef enum logic {
        DST_ACC,
        DST_BASE
    } dest_t;

    localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] EXP_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [10:0] EXP_ALL_ONE = 11'h7FF;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic signed [13:0] BIAS       = 14'sd1023;
    localparam logic signed [13:0] EXP_OVF    = 14'sd2047;
    localparam logic signed [13:0] EXP_TINY   = -14'sd60;
    localparam logic signed [12:0] EXP_SUBN   = -13'sd1022;
    localparam logic [5:0]  DIV_LAST    = 6'd55;
    localparam logic [5:0]  MUL_LAST    = 6'd4;

endpackage

// ===== hw/rtl/double_integer_power_core.sv =====
// Top level of the double integer power core: square-and-multiply on one shared float unit.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, base_bits, exponent  | into core
//  out     | out_valid, out_stall, power_bits,        | out of core
//          | domain_error                             |
//
// One shared binary64 unit runs up to 125 multiplies per item (four 27x27 partial products,
// normalize, round) and, for a negative exponent, one reciprocal (one quotient bit a cycle);
// each subnormal operand or result is shifted one bit a cycle. Rejected requests skip the
// unit and go straight to the output.
// Reset clears the sequencer and the output valid; no data storage needs clearing.
// in_stall is high while an item is at work; a stalled result holds in the output register.
module double_integer_power_core
    import dip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] base_bits,
    input  logic signed [63:0] exponent,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] power_bits,
    output logic        domain_error
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    dest_t  dest_reg, dest_next;

    logic [63:0] base_reg, base_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mag_reg, mag_next;
    logic        ph_reg, ph_next;
    logic        err_reg, err_next;
    logic [63:0] opa_reg, opa_next;
    logic [63:0] opb_reg, opb_next;
    logic        s_reg, s_next;
    logic signed [12:0] ea_reg, ea_next;
    logic signed [12:0] eb_reg, eb_next;
    logic [52:0] ma_reg, ma_next;
    logic [52:0] mb_reg, mb_next;
    logic [105:0] p_reg, p_next;
    logic signed [13:0] e_reg, e_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [53:0] prod_reg, prod_next;
    logic [1:0]  psh_reg, psh_next;
    logic [54:0] rem_reg, rem_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] power_bits_reg, power_bits_next;
    logic        domain_error_reg, domain_error_next;

    // operand decode
    logic [10:0] xa, xb;
    logic [51:0] fa, fb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic        wr_en;
    logic [63:0] wr_val;
    logic [26:0] mul_a, mul_b;
    logic [105:0] pp_ext;
    logic        div_ge;
    logic [54:0] div_diff;
    logic [10:0] rnd_exp;
    logic [63:0] rnd_packed;
    logic        rnd_up;
    logic signed [13:0] e_post;

    assign xa     = opa_reg[62:52];
    assign xb     = opb_reg[62:52];
    assign fa     = opa_reg[51:0];
    assign fb     = opb_reg[51:0];
    assign nan_a  = (xa == EXP_ALL_ONE) && (fa != 52'd0);
    assign nan_b  = (xb == EXP_ALL_ONE) && (fb != 52'd0);
    assign inf_a  = (xa == EXP_ALL_ONE) && (fa == 52'd0);
    assign inf_b  = (xb == EXP_ALL_ONE) && (fb == 52'd0);
    assign zero_a = (opa_reg[62:0] == 63'd0);
    assign zero_b = (opb_reg[62:0] == 63'd0);

    assign mul_a    = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
    assign mul_b    = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
    assign pp_ext   = (psh_reg == 2'd0) ? {52'd0, prod_reg}
                    : (psh_reg == 2'd1) ? {25'd0, prod_reg, 27'd0}
                    : {prod_reg[51:0], 54'd0};
    assign div_ge   = rem_reg >= {2'b00, mb_reg};
    assign div_diff = rem_reg - {2'b00, mb_reg};

    assign rnd_exp    = (e_reg == 14'sd1) ? {10'd0, p_reg[105]} : e_reg[10:0];
    assign rnd_packed = {s_reg, rnd_exp, p_reg[104:53]};
    assign rnd_up     = p_reg[52] & ((|p_reg[51:0]) | p_reg[53]);
    assign e_post     = (p_reg[105] ? e_reg + 14'sd1 : e_reg) + BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        dest_reg         <= dest_next;
        base_reg         <= base_next;
        acc_reg          <= acc_next;
        mag_reg          <= mag_next;
        ph_reg           <= ph_next;
        err_reg          <= err_next;
        opa_reg          <= opa_next;
        opb_reg          <= opb_next;
        s_reg            <= s_next;
        ea_reg           <= ea_next;
        eb_reg           <= eb_next;
        ma_reg           <= ma_next;
        mb_reg           <= mb_next;
        p_reg            <= p_next;
        e_reg            <= e_next;
        cnt_reg          <= cnt_next;
        prod_reg         <= prod_next;
        psh_reg          <= psh_next;
        rem_reg          <= rem_next;
        power_bits_reg   <= power_bits_next;
        domain_error_reg <= domain_error_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        dest_next         = dest_reg;
        base_next         = base_reg;
        acc_next          = acc_reg;
        mag_next          = mag_reg;
        ph_next           = ph_reg;
        err_next          = err_reg;
        opa_next          = opa_reg;
        opb_next          = opb_reg;
        s_next            = s_reg;
        ea_next           = ea_reg;
        eb_next           = eb_reg;
        ma_next           = ma_reg;
        mb_next           = mb_reg;
        p_next            = p_reg;
        e_next            = e_reg;
        cnt_next          = cnt_reg;
        prod_next         = prod_reg;
        psh_next          = psh_reg;
        rem_next          = rem_reg;
        power_bits_next   = power_bits_reg;
        domain_error_next = domain_error_reg;
        out_valid_next    = out_valid_reg && out_stall;
        wr_en             = 1'b0;
        wr_val            = rnd_packed + {63'd0, rnd_up};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    base_next = base_bits;
                    acc_next  = ONE_BITS;
                    ph_next   = 1'b0;
                    err_next  = 1'b0;
                    if ((exponent == EXP_MIN) || (exponent[63] && (base_bits[62:0] == 63'd0)))
                    begin
                        err_next   = 1'b1;
                        acc_next   = 64'd0;
                        state_next = S_DONE;
                    end
                    else if (exponent[63])
                    begin
                        mag_next   = (~exponent) + 64'd1;
                        op_next    = OP_RECIP;
                        dest_next  = DST_BASE;
                        opa_next   = ONE_BITS;
                        opb_next   = base_bits;
                        state_next = S_UNPACK;
                    end
                    else
                    begin
                        mag_next   = exponent;
                        state_next = S_LOOP;
                    end
                end
            end

            S_LOOP:
            begin
                op_next = OP_MUL;
                if (mag_reg == 64'd0)
                begin
                    state_next = S_DONE;
                end
                else if (!ph_reg && mag_reg[0])
                begin
                    opa_next   = acc_reg;
                    opb_next   = base_reg;
                    dest_next  = DST_ACC;
                    ph_next    = 1'b1;
                    state_next = S_UNPACK;
                end
                else if (mag_reg[63:1] != 63'd0)
                begin
                    opa_next   = base_reg;
                    opb_next   = base_reg;
                    dest_next  = DST_BASE;
                    ph_next    = 1'b0;
                    mag_next   = {1'b0, mag_reg[63:1]};
                    state_next = S_UNPACK;
                end
                else
                begin
                    // last set bit used: the final squaring is not needed
                    mag_next = 64'd0;
                end
            end

            S_UNPACK:
            begin
                ma_next = {(xa != 11'd0), fa};
                mb_next = {(xb != 11'd0), fb};
                ea_next = (xa == 11'd0) ? EXP_SUBN : $signed({2'b00, xa}) - 13'sd1023;
                eb_next = (xb == 11'd0) ? EXP_SUBN : $signed({2'b00, xb}) - 13'sd1023;
                state_next = S_NORM;
                if (op_reg == OP_MUL)
                begin
                    s_next = opa_reg[63] ^ opb_reg[63];
                    if (nan_a)
                    begin
                        wr_en = 1'b1;
                        wr_val = opa_reg | QUIET_BIT;
                    end
                    else if (nan_b)
                    begin
                        wr_en = 1'b1;
                        wr_val = opb_reg | QUIET_BIT;
                    end
                    else if ((inf_a && zero_b) || (zero_a && inf_b))
                    begin
                        wr_en = 1'b1;
                        wr_val = DEFAULT_NAN;
                    end
                    else if (inf_a || inf_b)
                    begin
                        wr_en = 1'b1;
                        wr_val = {opa_reg[63] ^ opb_reg[63], EXP_ALL_ONE, 52'd0};
                    end
                    else if (zero_a || zero_b)
                    begin
                        wr_en = 1'b1;
                        wr_val = {opa_reg[63] ^ opb_reg[63], 63'd0};
                    end
                end
                else
                begin
                    s_next = opb_reg[63];
                    if (nan_b)
                    begin
                        wr_en = 1'b1;
                        wr_val = opb_reg | QUIET_BIT;
                    end
                    else if (inf_b)
                    begin
                        wr_en = 1'b1;
                        wr_val = {opb_reg[63], 63'd0};
                    end
                    else if (zero_b)
                    begin
                        wr_en = 1'b1;
                        wr_val = {opb_reg[63], EXP_ALL_ONE, 52'd0};
                    end
                end
            end

            S_NORM:
            begin
                // one bit a cycle for subnormal operands
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - 13'sd1;
                end
                else if (!mb_reg[52])
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - 13'sd1;
                end
                else
                begin
                    cnt_next = 6'd0;
                    p_next   = 106'd0;
                    if (op_reg == OP_MUL)
                    begin
                        e_next     = 14'(ea_reg) + 14'(eb_reg);
                        state_next = S_MUL;
                    end
                    else
                    begin
                        e_next     = -14'(eb_reg) - 14'sd1;
                        rem_next   = {2'b00, 1'b1, 52'd0};
                        state_next = S_DIV;
                    end
                end
            end

            S_MUL:
            begin
                if (cnt_reg != 6'd0)
                begin
                    p_next = p_reg + pp_ext;
                end
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    prod_next = mul_a * mul_b;
                    psh_next  = 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
                    cnt_next  = cnt_reg + 6'd1;
                end
            end

            S_DIV:
            begin
                rem_next = div_ge ? {div_diff[53:0], 1'b0} : {rem_reg[53:0], 1'b0};
                if (cnt_reg == DIV_LAST)
                begin
                    p_next = {p_reg[54:0], div_ge, 49'd0,
                              (div_ge ? div_diff : rem_reg) != 55'd0};
                    state_next = S_POST;
                end
                else
                begin
                    p_next   = {p_reg[104:0], div_ge};
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            S_POST:
            begin
                if (!p_reg[105])
                begin
                    p_next = {p_reg[104:0], 1'b0};
                end
                e_next     = e_post;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (e_reg >= EXP_OVF)
                begin
                    wr_en  = 1'b1;
                    wr_val = {s_reg, EXP_ALL_ONE, 52'd0};
                end
                else if (e_reg < EXP_TINY)
                begin
                    // far below the smallest subnormal: only sticky survives
                    p_next     = {105'd0, 1'b1};
                    e_next     = 14'sd1;
                    state_next = S_ROUND;
                end
                else if (e_reg < 14'sd1)
                begin
                    state_next = S_DENORM;
                end
                else
                begin
                    state_next = S_ROUND;
                end
            end

            S_DENORM:
            begin
                if (e_reg == 14'sd1)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    p_next = {1'b0, p_reg[105:2], p_reg[1] | p_reg[0]};
                    e_next = e_reg + 14'sd1;
                end
            end

            S_ROUND:
            begin
                wr_en = 1'b1;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    power_bits_next   = acc_reg;
                    domain_error_next = err_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // retire a unit result into its destination
        if (wr_en)
        begin
            if (dest_reg == DST_ACC)
            begin
                acc_next = wr_val;
            end
            else
            begin
                base_next = wr_val;
            end
            state_next = S_LOOP;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_bits   = power_bits_reg;
    assign domain_error = domain_error_reg;

endmodule
